// ===== hw/rtl/icsg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsg_pkg
// Shared types and constants of the IR carrier symbol generator.
// ----------------------------------------------------------------------------
package icsg_pkg;

    localparam int HALF_W  = 15;
    localparam int REP_W   = 20;
    localparam int HZ_W    = 20;
    localparam int DUTY_W  = 16;
    localparam int PER_W   = 16;
    localparam int TICKS_W = 16;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 20;
    localparam int REM_W   = 16;

    localparam logic [IDX_W-1:0] REG_CARRIER_HZ    = 2'd0;
    localparam logic [IDX_W-1:0] REG_DUTY_FRACTION = 2'd1;
    localparam logic [IDX_W-1:0] REG_MARK_HIGH     = 2'd2;

    localparam logic [HZ_W-1:0]   RST_HZ     = 20'd38000;
    localparam logic [DUTY_W-1:0] RST_DUTY   = 16'h8000;
    localparam logic [PER_W-1:0]  RST_PERIOD = 16'd26;
    localparam logic [PER_W-1:0]  RST_HIGH   = 16'd13;
    localparam logic [PER_W-1:0]  RST_LOW    = 16'd13;

    localparam int PER_NUM     = 1000000;
    localparam int MAX_SYMBOLS = 11;
    localparam logic [REP_W-1:0] REP_MAX = 20'hFFFFF;

    localparam logic [1:0] DSEL_PERIOD = 2'd0;
    localparam logic [1:0] DSEL_MARK   = 2'd1;
    localparam logic [1:0] DSEL_RUN    = 2'd2;

    localparam logic [1:0] ESEL_MARK = 2'd0;
    localparam logic [1:0] ESEL_FULL = 2'd1;
    localparam logic [1:0] ESEL_FOLD = 2'd2;
    localparam logic [1:0] ESEL_REM  = 2'd3;

    typedef struct packed {
        logic       div_start;
        logic [1:0] dsel;
        logic       period_load;
        logic       derive_zero;
        logic       derive_mul;
        logic       derive_fin;
        logic       cfg_clear;
        logic       take_item;
        logic       qload;
        logic       emit;
        logic [1:0] esel;
        logic       emit_last;
        logic       dec_full;
    } icsg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic carrier;
        logic full_zero;
        logic full_one;
        logic rem_zero;
        logic fold;
        logic cfg_pend;
        logic cfg_we;
        logic hz_zero;
        logic in_valid;
    } icsg_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/icsg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsg_if
// Input and output word channels of the IR carrier symbol generator.
// ----------------------------------------------------------------------------
interface icsg_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] duration_ticks;
    logic        frame_last;
    modport source (output valid, output duration_ticks, output frame_last, input ready);
    modport sink (input valid, input duration_ticks, input frame_last, output ready);
endinterface

interface icsg_out_if;
    logic        valid;
    logic        ready;
    logic        first_level;
    logic [14:0] first_time;
    logic        second_level;
    logic [14:0] second_time;
    logic [19:0] rep_count;
    logic        item_end;
    modport source (output valid, output first_level, output first_time,
                    output second_level, output second_time, output rep_count,
                    output item_end, input ready);
    modport sink (input valid, input first_level, input first_time,
                  input second_level, input second_time, input rep_count,
                  input item_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ir_carrier_symbol_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_carrier_symbol_generator
// Turns mark/space durations into two-half line symbols with carrier cycles.
//
//   channel  dir  handshake     word
//   in_ch    in   valid/ready   duration_ticks, frame_last
//   out_ch   out  valid/ready   first/second level and time, repeat, item_end
//   cfg      in   cfg_we        cfg_index, cfg_wdata
//
// One item at a time: accept, a setup state that starts the shared restoring
// divider, the divide, its registered done flag, then one symbol per cycle
// while out_ch is not stalled, and a return to idle.
// A config write recomputes the carrier period and its high and low parts;
// in_ch is not ready meanwhile. Reset loads the default carrier.
// A stalled out_ch holds the sequencer at the next symbol.
// ----------------------------------------------------------------------------
module ir_carrier_symbol_generator #(
    parameter int MAX_HALF_US = 32767,
    parameter int TICK_US     = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    icsg_in_if.sink                          in_ch,
    icsg_out_if.source                       out_ch,
    input  wire logic                        cfg_we,
    input  wire logic [icsg_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [icsg_pkg::CFG_W-1:0]  cfg_wdata
);
    import icsg_pkg::*;

    icsg_cmd_t  cmd;
    icsg_stat_t stat;
    logic       in_ready;

    icsg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    icsg_datapath #(
        .MAX_HALF_US (MAX_HALF_US),
        .TICK_US     (TICK_US)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_ch.valid),
        .in_ticks         (in_ch.duration_ticks),
        .in_last          (in_ch.frame_last),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .out_first_level  (out_ch.first_level),
        .out_first_time   (out_ch.first_time),
        .out_second_level (out_ch.second_level),
        .out_second_time  (out_ch.second_time),
        .out_rep_count    (out_ch.rep_count),
        .out_item_end     (out_ch.item_end)
    );

    assign in_ch.ready = in_ready;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("word accepted while previous one in progress");

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ch.ready)
        else $error("input ready during carrier recompute");

    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_ch.valid && out_ch.rep_count != '0))
        else $error("emitted word with zero repeat count");
endmodule
`default_nettype wire

// ===== hw/rtl/icsg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module icsg_div #(
    parameter int DW = 24,
    parameter int VW = 20
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quot,
    output logic [VW-1:0]      rem
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] q_reg, q_next;
    logic [VW-1:0] r_reg, r_next;
    logic [VW-1:0] d_reg, d_next;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_reg, q_reg[DW-1]};
    assign fits  = trial >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            r_next   = fits ? VW'(trial - {1'b0, d_reg}) : trial[VW-1:0];
            q_next   = {q_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/icsg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsg_datapath
// Config and derived carrier registers, item registers, divider, output word.
// ----------------------------------------------------------------------------
module icsg_datapath #(
    parameter int MAX_HALF_US = 32767,
    parameter int TICK_US     = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire icsg_pkg::icsg_cmd_t       cmd,
    output icsg_pkg::icsg_stat_t           stat,
    input  wire logic                      cfg_we,
    input  wire logic [icsg_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [icsg_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                      in_valid,
    input  wire logic [icsg_pkg::TICKS_W-1:0] in_ticks,
    input  wire logic                      in_last,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic                           out_first_level,
    output logic [icsg_pkg::HALF_W-1:0]    out_first_time,
    output logic                           out_second_level,
    output logic [icsg_pkg::HALF_W-1:0]    out_second_time,
    output logic [icsg_pkg::REP_W-1:0]     out_rep_count,
    output logic                           out_item_end
);
    import icsg_pkg::*;

    localparam int US_W  = $clog2(65535 * TICK_US + 1);
    localparam int DW    = (US_W + 1 > 21) ? US_W + 1 : 21;
    localparam int SLICE = 2 * MAX_HALF_US;
    localparam logic [PER_W-1:0]  PCAP = PER_W'(SLICE);
    localparam logic [HALF_W-1:0] MAXH = HALF_W'(MAX_HALF_US);

    logic [HZ_W-1:0]   hz_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic              mlh_reg;
    logic              pend_reg;
    logic [PER_W-1:0]  period_reg, high_reg, low_reg;
    logic [32:0]       prod_reg;
    logic              exp_reg;
    logic [US_W-1:0]   us_reg;
    logic              lvl_reg;
    logic              carrier_reg;
    logic [DW-1:0]     full_reg;
    logic [REM_W-1:0]  rem_reg;
    logic              fold_reg;

    logic              ov_reg, fl_reg, sl_reg, end_reg;
    logic [HALF_W-1:0] ft_reg, st_reg;
    logic [REP_W-1:0]  rep_reg;

    logic [DW-1:0]     dvd;
    logic [HZ_W-1:0]   dvs;
    logic              div_done;
    logic [DW-1:0]     quot;
    logic [HZ_W-1:0]   rem;
    logic [16:0]       h_a, h_b;
    logic [DW:0]       need;

    logic              e_fl, e_sl;
    logic [HALF_W-1:0] e_ft, e_st;
    logic [REP_W-1:0]  e_rep;
    logic [DW-1:0]     cyc;

    function automatic logic [HALF_W-1:0] half_sat(input logic [PER_W-1:0] v);
        return (v > PER_W'(MAX_HALF_US)) ? MAXH : v[HALF_W-1:0];
    endfunction

    function automatic logic [REP_W-1:0] rep_sat(input logic [DW-1:0] v);
        return (v > DW'(REP_MAX)) ? REP_MAX : v[REP_W-1:0];
    endfunction

    always_comb
    begin
        unique case (cmd.dsel)
            DSEL_PERIOD:
            begin
                dvd = DW'(PER_NUM) + DW'(hz_reg >> 1);
                dvs = hz_reg;
            end
            DSEL_MARK:
            begin
                dvd = DW'(us_reg) + DW'(period_reg >> 1);
                dvs = HZ_W'(period_reg);
            end
            default:
            begin
                dvd = DW'(us_reg);
                dvs = HZ_W'(SLICE);
            end
        endcase
    end

    icsg_div #(.DW(DW), .VW(HZ_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    assign h_a  = (prod_reg[32:16] == 17'd0) ? 17'd1 : prod_reg[32:16];
    assign h_b  = (h_a >= {1'b0, period_reg}) ? ({1'b0, period_reg} - 17'd1) : h_a;
    assign need = {1'b0, quot} + (DW + 1)'(rem != '0);
    assign cyc  = (full_reg == '0) ? DW'(1) : full_reg;

    always_comb
    begin
        e_fl  = lvl_reg;
        e_sl  = lvl_reg;
        e_ft  = MAXH;
        e_st  = MAXH;
        e_rep = REP_W'(1);
        unique case (cmd.esel)
            ESEL_MARK:
            begin
                e_sl  = ~lvl_reg;
                e_ft  = half_sat(high_reg);
                e_st  = half_sat(low_reg);
                e_rep = rep_sat(cyc);
            end
            ESEL_FULL: ;
            ESEL_FOLD: e_rep = rep_sat(full_reg);
            default:
            begin
                if (rem_reg > REM_W'(MAX_HALF_US))
                begin
                    e_st = HALF_W'(rem_reg - REM_W'(MAX_HALF_US));
                end
                else if (rem_reg > REM_W'(1))
                begin
                    e_ft = HALF_W'(rem_reg - (rem_reg >> 1));
                    e_st = HALF_W'(rem_reg >> 1);
                end
                else
                begin
                    e_ft = HALF_W'(1);
                    e_st = HALF_W'(1);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hz_reg     <= RST_HZ;
            duty_reg   <= RST_DUTY;
            mlh_reg    <= 1'b1;
            pend_reg   <= 1'b0;
            period_reg <= RST_PERIOD;
            high_reg   <= RST_HIGH;
            low_reg    <= RST_LOW;
            exp_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CARRIER_HZ:    hz_reg   <= cfg_wdata[HZ_W-1:0];
                    REG_DUTY_FRACTION: duty_reg <= cfg_wdata[DUTY_W-1:0];
                    REG_MARK_HIGH:     mlh_reg  <= cfg_wdata[0];
                    default: ;
                endcase
                pend_reg <= 1'b1;
            end
            else if (cmd.cfg_clear)
            begin
                pend_reg <= 1'b0;
            end
            if (cmd.derive_zero)
            begin
                period_reg <= '0;
                high_reg   <= '0;
                low_reg    <= '0;
            end
            if (cmd.period_load)
            begin
                period_reg <= (quot > DW'(PCAP)) ? PCAP : quot[PER_W-1:0];
            end
            if (cmd.derive_fin)
            begin
                high_reg <= h_b[PER_W-1:0];
                low_reg  <= period_reg - h_b[PER_W-1:0];
            end
            if (cmd.take_item)
            begin
                exp_reg <= in_last ? 1'b0 : ~exp_reg;
            end
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.derive_mul)
        begin
            prod_reg <= 33'(period_reg) * 33'(duty_reg) + 33'd32768;
        end
        if (cmd.take_item)
        begin
            us_reg      <= US_W'(in_ticks * TICK_US);
            lvl_reg     <= exp_reg ? ~mlh_reg : mlh_reg;
            carrier_reg <= !exp_reg && (period_reg != '0);
        end
        if (cmd.qload)
        begin
            full_reg <= quot;
            rem_reg  <= rem[REM_W-1:0];
            fold_reg <= need > (DW + 1)'(MAX_SYMBOLS);
        end
        else if (cmd.dec_full)
        begin
            full_reg <= fold_reg ? '0 : full_reg - DW'(1);
        end
        if (cmd.emit)
        begin
            fl_reg  <= e_fl;
            ft_reg  <= e_ft;
            sl_reg  <= e_sl;
            st_reg  <= e_st;
            rep_reg <= e_rep;
            end_reg <= cmd.emit_last;
        end
    end

    assign stat.div_done  = div_done;
    assign stat.out_free  = !ov_reg || out_ready;
    assign stat.carrier   = carrier_reg;
    assign stat.full_zero = full_reg == '0;
    assign stat.full_one  = full_reg == DW'(1);
    assign stat.rem_zero  = rem_reg == '0;
    assign stat.fold      = fold_reg;
    assign stat.cfg_pend  = pend_reg;
    assign stat.cfg_we    = cfg_we;
    assign stat.hz_zero   = hz_reg == '0;
    assign stat.in_valid  = in_valid;

    assign out_valid        = ov_reg;
    assign out_first_level  = fl_reg;
    assign out_first_time   = ft_reg;
    assign out_second_level = sl_reg;
    assign out_second_time  = st_reg;
    assign out_rep_count    = rep_reg;
    assign out_item_end     = end_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/icsg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icsg_ctrl
// Sequencer: carrier derivation after config writes, per-item divide and emit.
// ----------------------------------------------------------------------------
module icsg_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire icsg_pkg::icsg_stat_t stat,
    output icsg_pkg::icsg_cmd_t       cmd,
    output logic                      in_ready
);
    import icsg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DDIV  = 3'd1;
    localparam logic [2:0] S_DMUL  = 3'd2;
    localparam logic [2:0] S_DFIN  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_IDIV  = 3'd5;
    localparam logic [2:0] S_MARK  = 3'd6;
    localparam logic [2:0] S_RUN   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       last;

    assign in_ready = (state_reg == S_IDLE) && !stat.cfg_pend && !stat.cfg_we;
    assign last     = (stat.fold || stat.full_one) && stat.rem_zero;

    always_comb
    begin
        cmd        = '0;
        cmd.dsel   = DSEL_PERIOD;
        cmd.esel   = ESEL_MARK;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.cfg_pend)
                begin
                    cmd.cfg_clear = 1'b1;
                    if (stat.hz_zero)
                    begin
                        cmd.derive_zero = 1'b1;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DDIV;
                    end
                end
                else if (in_ready && stat.in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_START;
                end
            end
            S_DDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.period_load = 1'b1;
                    state_next      = S_DMUL;
                end
            end
            S_DMUL:
            begin
                cmd.derive_mul = 1'b1;
                state_next     = S_DFIN;
            end
            S_DFIN:
            begin
                cmd.derive_fin = 1'b1;
                state_next     = S_IDLE;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                cmd.dsel      = stat.carrier ? DSEL_MARK : DSEL_RUN;
                state_next    = S_IDIV;
            end
            S_IDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.qload  = 1'b1;
                    state_next = stat.carrier ? S_MARK : S_RUN;
                end
            end
            S_MARK:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.esel      = ESEL_MARK;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                if (!stat.full_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.esel      = stat.fold ? ESEL_FOLD : ESEL_FULL;
                        cmd.emit_last = last;
                        cmd.dec_full  = 1'b1;
                        if (last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (!stat.rem_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.esel      = ESEL_REM;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/ir_carrier_symbol_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_carrier_symbol_generator_tb
// Checks the symbol generator against its own symbol predictor. Durations are
// driven through several carrier, duty and polarity settings, with random
// idling on both channels; every output word is compared field by field.
// ----------------------------------------------------------------------------
module ir_carrier_symbol_generator_tb;
    import icsg_pkg::*;

    localparam int HALF_MAX  = 32767;
    localparam int TICK      = 10;
    localparam int WDOG_MAX  = 3000;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        bit        first_level;
        bit [14:0] first_time;
        bit        second_level;
        bit [14:0] second_time;
        bit [19:0] rep_count;
        bit        item_end;
    } symbol_t;

    typedef struct {
        bit [15:0] ticks;
        bit        last;
    } duration_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    icsg_in_if  in_ch ();
    icsg_out_if out_ch ();

    ir_carrier_symbol_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    duration_t durations_q[$];
    symbol_t   symbols_q[$];
    duration_t held_word;
    int        errors = 0;
    int        cycle = 0;
    int        idle_cycles = 0;

    // predictor state
    bit [19:0] hz_r;
    bit [15:0] duty_r;
    bit        mark_high_r;
    bit        in_space;
    int unsigned period_r, high_r, low_r;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic void derive_carrier();
        longint unsigned p, h;
        p = 0;
        h = 0;
        if (hz_r != 0) begin
            p = (64'd1000000 + hz_r / 2) / hz_r;
            if (p > 2 * HALF_MAX)
                p = 2 * HALF_MAX;
            h = (p * duty_r + 32768) >> 16;
            if (h < 1)
                h = 1;
            if (h >= p)
                h = p - 1;
        end
        period_r = 32'(p);
        high_r = 32'(h);
        low_r = 32'(p - h);
    endfunction

    function automatic bit [14:0] sat_half(int unsigned v);
        return (v > HALF_MAX) ? 15'(HALF_MAX) : 15'(v);
    endfunction

    function automatic void push_symbol(bit l0, int unsigned t0, bit l1, int unsigned t1,
                                        int unsigned rep);
        symbol_t s;
        s.first_level = l0;
        s.first_time = sat_half(t0);
        s.second_level = l1;
        s.second_time = sat_half(t1);
        s.rep_count = (rep > 32'hFFFFF) ? 20'hFFFFF : 20'(rep);
        s.item_end = 1'b0;
        symbols_q.insert(symbols_q.size(), s);
    endfunction

    function automatic void push_run(bit lvl, int unsigned us);
        int unsigned slice, full, rem, need;
        slice = 2 * HALF_MAX;
        full = us / slice;
        rem = us % slice;
        need = full + (rem != 0);
        if (need > MAX_SYMBOLS)
            push_symbol(lvl, HALF_MAX, lvl, HALF_MAX, full);
        else
            for (int i = 0; i < full; i++)
                push_symbol(lvl, HALF_MAX, lvl, HALF_MAX, 1);
        if (rem > HALF_MAX)
            push_symbol(lvl, HALF_MAX, lvl, rem - HALF_MAX, 1);
        else if (rem > 1)
            push_symbol(lvl, rem - rem / 2, lvl, rem / 2, 1);
        else if (rem == 1)
            push_symbol(lvl, 1, lvl, 1, 1);
    endfunction

    function automatic void predict_symbols(duration_t d);
        int unsigned us, cyc, base_count;
        us = d.ticks * TICK;
        base_count = symbols_q.size();
        if (!in_space) begin
            if (period_r > 0) begin
                cyc = (us + period_r / 2) / period_r;
                if (cyc < 1)
                    cyc = 1;
                push_symbol(mark_high_r, high_r, !mark_high_r, low_r, cyc);
            end
            else begin
                push_run(mark_high_r, us);
            end
        end
        else begin
            push_run(!mark_high_r, us);
        end
        if (symbols_q.size() > base_count)
            symbols_q[$].item_end = 1'b1;
        in_space = d.last ? 1'b0 : !in_space;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle, what);
        errors++;
    endtask

    function automatic bit idle_now();
        if ((cycle % 5000) < 1200)
            return 1'b0;
        return $urandom_range(99) < 20;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n) begin
        bit took;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.duration_ticks <= '0;
            in_ch.frame_last <= 1'b0;
        end
        else begin
            took = in_ch.valid && in_ch.ready;
            if (took)
                predict_symbols(held_word);
            if (!in_ch.valid || took) begin
                if (durations_q.size() > 0 && !idle_now()) begin
                    held_word = durations_q[0];
                    durations_q.delete(0);
                    in_ch.valid <= 1'b1;
                    in_ch.duration_ticks <= held_word.ticks;
                    in_ch.frame_last <= held_word.last;
                end
                else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n) begin
        symbol_t s;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end
        else begin
            cycle <= cycle + 1;
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                if (symbols_q.size() == 0) begin
                    report_mismatch("unexpected word");
                end
                else begin
                    s = symbols_q[0];
                    symbols_q.delete(0);
                    if (out_ch.first_level !== s.first_level)
                        report_mismatch($sformatf("first_level %b exp %b",
                                        out_ch.first_level, s.first_level));
                    if (out_ch.first_time !== s.first_time)
                        report_mismatch($sformatf("first_time %0d exp %0d",
                                        out_ch.first_time, s.first_time));
                    if (out_ch.second_level !== s.second_level)
                        report_mismatch($sformatf("second_level %b exp %b",
                                        out_ch.second_level, s.second_level));
                    if (out_ch.second_time !== s.second_time)
                        report_mismatch($sformatf("second_time %0d exp %0d",
                                        out_ch.second_time, s.second_time));
                    if (out_ch.rep_count !== s.rep_count)
                        report_mismatch($sformatf("rep_count %0d exp %0d",
                                        out_ch.rep_count, s.rep_count));
                    if (out_ch.item_end !== s.item_end)
                        report_mismatch($sformatf("item_end %b exp %b",
                                        out_ch.item_end, s.item_end));
                end
            end
            out_ch.ready <= !idle_now();
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(bit [IDX_W-1:0] idx, bit [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CARRIER_HZ)
            hz_r = val;
        else if (idx == REG_DUTY_FRACTION)
            duty_r = val[15:0];
        else if (idx == REG_MARK_HIGH)
            mark_high_r = val[0];
        else
            return;
        derive_carrier();
    endtask

    task automatic add_duration(bit [15:0] t, bit l);
        duration_t d;
        d.ticks = t;
        d.last = l;
        durations_q.insert(durations_q.size(), d);
    endtask

    task automatic add_random(int n);
        bit [15:0] t;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: t = 16'($urandom);
                1: t = 16'($urandom_range(20));
                default: t = 16'($urandom_range(4000));
            endcase
            add_duration(t, $urandom_range(5) == 0);
        end
    endtask

    task automatic drain();
        wait (durations_q.size() == 0 && !in_ch.valid && symbols_q.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    initial begin
        hz_r = RST_HZ;
        duty_r = RST_DUTY;
        mark_high_r = 1'b1;
        in_space = 1'b0;
        derive_carrier();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // default carrier: extremes, zero space, frame ends
        add_duration(16'd0, 1'b0);
        add_duration(16'd0, 1'b0);
        add_duration(16'hFFFF, 1'b0);
        add_duration(16'hFFFF, 1'b0);
        add_duration(16'd1, 1'b1);
        add_duration(16'd100, 1'b0);
        add_duration(16'd1, 1'b0);
        add_duration(16'd3277, 1'b0);
        add_duration(16'd6553, 1'b0);
        add_duration(16'd6554, 1'b1);
        add_random(15);
        drain();

        // solid marks, inverted polarity
        write_reg(REG_CARRIER_HZ, 20'd0);
        write_reg(REG_MARK_HIGH, 20'd0);
        write_reg(REG_UNUSED, 20'hFFFFF);
        add_duration(16'd0, 1'b0);
        add_duration(16'd5, 1'b0);
        add_duration(16'hFFFF, 1'b0);
        add_duration(16'd3276, 1'b1);
        add_random(20);
        drain();

        // period of one
        write_reg(REG_CARRIER_HZ, 20'd1000000);
        write_reg(REG_DUTY_FRACTION, 20'd1);
        write_reg(REG_MARK_HIGH, 20'd1);
        add_duration(16'd0, 1'b0);
        add_duration(16'd3, 1'b0);
        add_duration(16'hFFFF, 1'b1);
        add_random(15);
        drain();

        // very low carrier: capped period, wide halves
        write_reg(REG_CARRIER_HZ, 20'd1);
        write_reg(REG_DUTY_FRACTION, 20'hFFFF);
        add_duration(16'hFFFF, 1'b1);
        add_random(15);
        drain();

        write_reg(REG_CARRIER_HZ, 20'hFFFFF);
        write_reg(REG_DUTY_FRACTION, 20'hF0000);
        add_random(15);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            write_reg(REG_CARRIER_HZ, $urandom_range(3) == 0 ? 20'($urandom) :
                      20'($urandom_range(20000, 60000)));
            write_reg(REG_DUTY_FRACTION, 20'($urandom));
            write_reg(REG_MARK_HIGH, 20'($urandom));
            add_random(15);
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/icsg_pkg.sv
hw/rtl/icsg_if.sv
hw/rtl/icsg_div.sv
hw/rtl/icsg_datapath.sv
hw/rtl/icsg_ctrl.sv
hw/rtl/ir_carrier_symbol_generator.sv
tb/sv/ir_carrier_symbol_generator_tb.sv
